FILE: rtl/core/owb_pkg.sv
// ----------------------------------------------------------------------------
// owb_pkg
// Types and constants shared by the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owb_pkg;

   localparam int CFG_WIDTH   = 10;
   localparam int CFG_COUNT   = 8;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int FUNC_WIDTH  = 3;
   localparam int BYTE_WIDTH  = 8;
   localparam int BIT_IDX_W   = 3;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_TICK      = 3'd0,
      FUNC_RESET     = 3'd1,
      FUNC_WRITE     = 3'd2,
      FUNC_READ_BYTE = 3'd3,
      FUNC_READ_BIT  = 3'd4
   } func_type;

   typedef enum logic [BIT_IDX_W-1:0] {
      REG_RESET_LOW    = 3'd0,
      REG_PRESENCE     = 3'd1,
      REG_RESET_REC    = 3'd2,
      REG_SLOT_LOW     = 3'd3,
      REG_WRITE_HOLD   = 3'd4,
      REG_WRITE_REC    = 3'd5,
      REG_READ_SAMPLE  = 3'd6,
      REG_READ_REC     = 3'd7
   } reg_index_type;

   typedef enum logic [8:0] {
      PH_IDLE     = 9'b000000001,
      PH_RST_LOW  = 9'b000000010,
      PH_RST_WAIT = 9'b000000100,
      PH_RST_REC  = 9'b000001000,
      PH_SLOT_LOW = 9'b000010000,
      PH_W_HOLD   = 9'b000100000,
      PH_W_REC    = 9'b001000000,
      PH_R_WAIT   = 9'b010000000,
      PH_R_REC    = 9'b100000000
   } phase_type;

   localparam logic [CFG_WIDTH-1:0] DEF_RESET_LOW   = 10'd480;
   localparam logic [CFG_WIDTH-1:0] DEF_PRESENCE    = 10'd100;
   localparam logic [CFG_WIDTH-1:0] DEF_RESET_REC   = 10'd380;
   localparam logic [CFG_WIDTH-1:0] DEF_SLOT_LOW    = 10'd2;
   localparam logic [CFG_WIDTH-1:0] DEF_WRITE_HOLD  = 10'd58;
   localparam logic [CFG_WIDTH-1:0] DEF_WRITE_REC   = 10'd1;
   localparam logic [CFG_WIDTH-1:0] DEF_READ_SAMPLE = 10'd10;
   localparam logic [CFG_WIDTH-1:0] DEF_READ_REC    = 10'd49;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] reset_low_ticks;
      logic [CFG_WIDTH-1:0] presence_wait_ticks;
      logic [CFG_WIDTH-1:0] reset_recovery_ticks;
      logic [CFG_WIDTH-1:0] slot_low_ticks;
      logic [CFG_WIDTH-1:0] write_hold_ticks;
      logic [CFG_WIDTH-1:0] write_recovery_ticks;
      logic [CFG_WIDTH-1:0] read_sample_ticks;
      logic [CFG_WIDTH-1:0] read_recovery_ticks;
   } cfg_type;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  line_in;
   } req_item_type;

   typedef struct packed {
      logic                  drive_low;
      logic                  busy_res;
      logic                  done_res;
      logic                  presence;
      logic [BYTE_WIDTH-1:0] read_data;
   } rsp_item_type;

   typedef struct packed {
      logic push;
      logic room;
   } buf_ctrl_type;

endpackage

FILE: rtl/core/owb_if.sv
// ----------------------------------------------------------------------------
// owb request and response channels
// Valid/ready channels carrying the tick request and the per-tick result.
// ----------------------------------------------------------------------------
interface owb_req_if;
   logic                          valid;
   logic                          ready;
   logic [owb_pkg::FUNC_WIDTH-1:0] func;
   logic [owb_pkg::BYTE_WIDTH-1:0] data_byte;
   logic                          line_in;

   modport source (output valid, output func, output data_byte, output line_in,
                   input ready);
   modport sink   (input valid, input func, input data_byte, input line_in,
                   output ready);
endinterface

interface owb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          drive_low;
   logic                          busy_res;
   logic                          done_res;
   logic                          presence;
   logic [owb_pkg::BYTE_WIDTH-1:0] read_data;

   modport source (output valid, output drive_low, output busy_res,
                   output done_res, output presence, output read_data,
                   input ready);
   modport sink   (input valid, input drive_low, input busy_res,
                   input done_res, input presence, input read_data,
                   output ready);
endinterface

FILE: rtl/core/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master stepped by one timing tick per request.
// A request reaches rsp through the request register and then the result register.
// Throughput: one request per cycle while the skid entry is free; the request
// register and skid entry let requests flow while a result waits to be taken.
// Reset: timing registers return to their defaults, the sequencer to idle.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   owb_req_if.sink                         req,
   owb_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [owb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [owb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [owb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   owb_pkg::cfg_type      cfg;
   owb_pkg::req_item_type req_item;
   owb_pkg::rsp_item_type eng_item;
   owb_pkg::rsp_item_type buf_item;
   owb_pkg::buf_ctrl_type buf_ctrl;
   logic                  buf_room;

   assign req_item.func      = req.func;
   assign req_item.data_byte = req.data_byte;
   assign req_item.line_in   = req.line_in;

   owb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   owb_engine #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (req.valid),
      .in_ready      (req.ready),
      .in_item       (req_item),
      .out_ctrl_push (buf_ctrl),
      .out_room      (buf_room),
      .out_item      (eng_item)
   );

   owb_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (buf_ctrl),
      .push_item (eng_item),
      .room      (buf_room),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_item  (buf_item)
   );

   assign rsp.drive_low = buf_item.drive_low;
   assign rsp.busy_res  = buf_item.busy_res;
   assign rsp.done_res  = buf_item.done_res;
   assign rsp.presence  = buf_item.presence;
   assign rsp.read_data = buf_item.read_data;

endmodule

FILE: rtl/core/owb_csr.sv
// ----------------------------------------------------------------------------
// owb_csr
// APB-style register file holding the eight slot timing registers.
// ----------------------------------------------------------------------------
module owb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [owb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [owb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [owb_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output owb_pkg::cfg_type                 cfg
);

   owb_pkg::cfg_type              cfg_ff;
   owb_pkg::cfg_type              cfg_in;
   owb_pkg::reg_index_type        idx;
   logic [owb_pkg::CFG_WIDTH-1:0] wdata;
   logic [owb_pkg::CFG_WIDTH-1:0] rdata;
   logic                          wr_en;

   assign idx    = owb_pkg::reg_index_type'(paddr[owb_pkg::CSR_ADDR_W-1:2]);
   assign wdata  = pwdata[owb_pkg::CFG_WIDTH-1:0];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      rdata  = '0;
      case (idx)
         owb_pkg::REG_RESET_LOW: begin
            rdata = cfg_ff.reset_low_ticks;
            if (wr_en) cfg_in.reset_low_ticks = wdata;
         end
         owb_pkg::REG_PRESENCE: begin
            rdata = cfg_ff.presence_wait_ticks;
            if (wr_en) cfg_in.presence_wait_ticks = wdata;
         end
         owb_pkg::REG_RESET_REC: begin
            rdata = cfg_ff.reset_recovery_ticks;
            if (wr_en) cfg_in.reset_recovery_ticks = wdata;
         end
         owb_pkg::REG_SLOT_LOW: begin
            rdata = cfg_ff.slot_low_ticks;
            if (wr_en) cfg_in.slot_low_ticks = wdata;
         end
         owb_pkg::REG_WRITE_HOLD: begin
            rdata = cfg_ff.write_hold_ticks;
            if (wr_en) cfg_in.write_hold_ticks = wdata;
         end
         owb_pkg::REG_WRITE_REC: begin
            rdata = cfg_ff.write_recovery_ticks;
            if (wr_en) cfg_in.write_recovery_ticks = wdata;
         end
         owb_pkg::REG_READ_SAMPLE: begin
            rdata = cfg_ff.read_sample_ticks;
            if (wr_en) cfg_in.read_sample_ticks = wdata;
         end
         owb_pkg::REG_READ_REC: begin
            rdata = cfg_ff.read_recovery_ticks;
            if (wr_en) cfg_in.read_recovery_ticks = wdata;
         end
         default: begin
            rdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks      <= owb_pkg::DEF_RESET_LOW;
         cfg_ff.presence_wait_ticks  <= owb_pkg::DEF_PRESENCE;
         cfg_ff.reset_recovery_ticks <= owb_pkg::DEF_RESET_REC;
         cfg_ff.slot_low_ticks       <= owb_pkg::DEF_SLOT_LOW;
         cfg_ff.write_hold_ticks     <= owb_pkg::DEF_WRITE_HOLD;
         cfg_ff.write_recovery_ticks <= owb_pkg::DEF_WRITE_REC;
         cfg_ff.read_sample_ticks    <= owb_pkg::DEF_READ_SAMPLE;
         cfg_ff.read_recovery_ticks  <= owb_pkg::DEF_READ_REC;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign prdata = owb_pkg::CSR_DATA_W'(rdata);
   assign cfg    = cfg_ff;

endmodule

FILE: rtl/core/owb_engine.sv
// ----------------------------------------------------------------------------
// owb_engine
// Request register and slot sequencer; one tick of bus timing per request.
// ----------------------------------------------------------------------------
module owb_engine #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  owb_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  owb_pkg::req_item_type in_item,
   output owb_pkg::buf_ctrl_type out_ctrl_push,
   input  logic                  out_room,
   output owb_pkg::rsp_item_type out_item
);

   localparam int LEN_WIDTH = (COUNT_WIDTH > owb_pkg::CFG_WIDTH) ?
                              COUNT_WIDTH : owb_pkg::CFG_WIDTH;
   localparam logic [LEN_WIDTH-1:0] COUNT_MAX = LEN_WIDTH'((1 << COUNT_WIDTH) - 1);
   localparam logic [LEN_WIDTH-1:0] LEN_ONE   = LEN_WIDTH'(1);

   logic                  req_valid_ff;
   owb_pkg::req_item_type req_item_ff;
   logic                  advance;

   owb_pkg::phase_type              phase_ff,    phase_in;
   logic [owb_pkg::FUNC_WIDTH-1:0]  op_ff,       op_in;
   logic [COUNT_WIDTH-1:0]          tick_ff,     tick_in;
   logic [owb_pkg::BIT_IDX_W-1:0]   bit_ff,      bit_in;
   logic [owb_pkg::BYTE_WIDTH-1:0]  shift_ff,    shift_in;
   logic                            pres_ff,     pres_in;

   logic                            start;
   logic [owb_pkg::CFG_WIDTH-1:0]   cfg_sel;
   logic [LEN_WIDTH-1:0]            len_raw;
   logic [LEN_WIDTH-1:0]            len_wide;
   logic [COUNT_WIDTH:0]            tick_plus;
   logic                            last;
   logic                            drive;
   logic                            done;
   logic                            is_read;

   assign advance  = req_valid_ff & out_room;
   assign in_ready = ~req_valid_ff | out_room;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (in_ready) begin
         req_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready & in_valid) begin
         req_item_ff <= in_item;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      drive    = 1'b0;
      done     = 1'b0;
      cfg_sel  = '0;
      len_raw  = '0;
      len_wide = '0;
      tick_plus = '0;
      last     = 1'b0;

      start = (phase_ff == owb_pkg::PH_IDLE) &&
              (req_item_ff.func >= owb_pkg::FUNC_RESET) &&
              (req_item_ff.func <= owb_pkg::FUNC_READ_BIT);
      if (start) begin
         op_in    = req_item_ff.func;
         tick_in  = '0;
         bit_in   = '0;
         shift_in = (req_item_ff.func == owb_pkg::FUNC_WRITE) ? req_item_ff.data_byte : '0;
         if (req_item_ff.func == owb_pkg::FUNC_RESET) begin
            pres_in  = 1'b0;
            phase_in = owb_pkg::PH_RST_LOW;
         end else begin
            phase_in = owb_pkg::PH_SLOT_LOW;
         end
      end

      case (phase_in)
         owb_pkg::PH_RST_LOW:  cfg_sel = cfg.reset_low_ticks;
         owb_pkg::PH_RST_WAIT: cfg_sel = cfg.presence_wait_ticks;
         owb_pkg::PH_RST_REC:  cfg_sel = cfg.reset_recovery_ticks;
         owb_pkg::PH_SLOT_LOW: cfg_sel = cfg.slot_low_ticks;
         owb_pkg::PH_W_HOLD:   cfg_sel = cfg.write_hold_ticks;
         owb_pkg::PH_W_REC:    cfg_sel = cfg.write_recovery_ticks;
         owb_pkg::PH_R_WAIT:   cfg_sel = cfg.read_sample_ticks;
         owb_pkg::PH_R_REC:    cfg_sel = cfg.read_recovery_ticks;
         default:              cfg_sel = '0;
      endcase

      len_raw   = LEN_WIDTH'(cfg_sel);
      len_wide  = (len_raw > COUNT_MAX) ? COUNT_MAX : len_raw;
      if (len_wide == '0) len_wide = LEN_ONE;
      tick_plus = {1'b0, tick_in} + (COUNT_WIDTH+1)'(1);
      last      = tick_plus >= {1'b0, len_wide[COUNT_WIDTH-1:0]};

      if (phase_in != owb_pkg::PH_IDLE) begin
         if (phase_in == owb_pkg::PH_RST_LOW || phase_in == owb_pkg::PH_SLOT_LOW) begin
            drive = 1'b1;
         end else if (phase_in == owb_pkg::PH_W_HOLD) begin
            drive = ~shift_in[bit_in];
         end

         if (!last) begin
            tick_in = tick_plus[COUNT_WIDTH-1:0];
         end else begin
            tick_in = '0;
            case (phase_in)
               owb_pkg::PH_RST_LOW: begin
                  phase_in = owb_pkg::PH_RST_WAIT;
               end
               owb_pkg::PH_RST_WAIT: begin
                  pres_in  = ~req_item_ff.line_in;
                  phase_in = owb_pkg::PH_RST_REC;
               end
               owb_pkg::PH_RST_REC: begin
                  phase_in = owb_pkg::PH_IDLE;
                  done     = 1'b1;
               end
               owb_pkg::PH_SLOT_LOW: begin
                  phase_in = (op_in == owb_pkg::FUNC_WRITE) ?
                             owb_pkg::PH_W_HOLD : owb_pkg::PH_R_WAIT;
               end
               owb_pkg::PH_W_HOLD: begin
                  phase_in = owb_pkg::PH_W_REC;
               end
               owb_pkg::PH_R_WAIT: begin
                  shift_in[bit_in] = shift_in[bit_in] | req_item_ff.line_in;
                  phase_in = owb_pkg::PH_R_REC;
               end
               default: begin
                  if (op_in == owb_pkg::FUNC_READ_BIT || bit_in == '1) begin
                     phase_in = owb_pkg::PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     bit_in   = bit_in + owb_pkg::BIT_IDX_W'(1);
                     phase_in = owb_pkg::PH_SLOT_LOW;
                  end
               end
            endcase
         end
      end

      is_read = (op_in == owb_pkg::FUNC_READ_BYTE) || (op_in == owb_pkg::FUNC_READ_BIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= owb_pkg::PH_IDLE;
         op_ff    <= '0;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         pres_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pres_ff  <= pres_in;
      end
   end

   assign out_ctrl_push.push = advance;
   assign out_ctrl_push.room = out_room;
   assign out_item.drive_low = drive;
   assign out_item.busy_res  = (phase_in != owb_pkg::PH_IDLE);
   assign out_item.done_res  = done;
   assign out_item.presence  = pres_in;
   assign out_item.read_data = is_read ? shift_in : '0;

endmodule

FILE: rtl/core/owb_out_buf.sv
// ----------------------------------------------------------------------------
// owb_out_buf
// Result register with a skid entry, decoupling the sequencer from the sink.
// ----------------------------------------------------------------------------
module owb_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  owb_pkg::buf_ctrl_type ctrl,
   input  owb_pkg::rsp_item_type push_item,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output owb_pkg::rsp_item_type out_item
);

   logic                  main_valid_ff;
   logic                  skid_valid_ff;
   owb_pkg::rsp_item_type main_item_ff;
   owb_pkg::rsp_item_type skid_item_ff;
   logic                  pop;

   assign pop       = main_valid_ff & out_ready;
   assign room      = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= ctrl.push;
         end else begin
            main_valid_ff <= ctrl.push;
         end
      end else if (ctrl.push) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            main_item_ff <= skid_item_ff;
            if (ctrl.push) skid_item_ff <= push_item;
         end else if (ctrl.push) begin
            main_item_ff <= push_item;
         end
      end else if (ctrl.push) begin
         if (main_valid_ff) begin
            skid_item_ff <= push_item;
         end else begin
            main_item_ff <= push_item;
         end
      end
   end

endmodule
